### hw/rtl/hbp_pkg.sv
// hbp_pkg: shared types and constants for the huffman bit packer
// no dependencies; imported by every module of the block

package hbp_pkg;

  localparam int MAX_CODE_LEN = 24;
  localparam int NUM_SYMBOLS  = 257;
  localparam int SYM_W        = 9;
  localparam int LEN_W        = 5;
  localparam int WORD_W       = 24;
  localparam int BYTE_W       = 8;

  localparam logic [SYM_W-1:0]  END_SYMBOL = SYM_W'(256);
  localparam logic [WORD_W-1:0] WORD_MASK  = {WORD_W{1'b1}};

  // opcodes of an input request
  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_ENCODE = 2'd1;
  localparam logic [1:0] OP_END    = 2'd2;

  // one input item can yield up to four bytes
  localparam int GRP_BYTES = 4;
  localparam int BIDX_W    = 2;
  localparam int GCNT_W    = 3;
  localparam int ACC_W     = GRP_BYTES * BYTE_W;

  // group queue
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  typedef struct packed {
    logic [1:0]        opcode;
    logic [SYM_W-1:0]  symbol;
    logic [LEN_W-1:0]  code_len;
    logic [WORD_W-1:0] code_word;
    logic [BYTE_W-1:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              stream_end;
  } out_t;

  // one code table entry
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [WORD_W-1:0] word;
  } entry_t;

  // bytes produced by one encode or end request, first byte at index 0
  typedef struct packed {
    logic [GRP_BYTES-1:0][BYTE_W-1:0] bytes;
    logic [GCNT_W-1:0]                nbytes;
    logic                             is_end;
  } grp_t;

endpackage

### hw/rtl/hbp_table.sv
// hbp_table: 257-entry code table, one write port and one registered read port
// depends on hbp_pkg

module hbp_table import hbp_pkg::*; (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [SYM_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic             rd_en,
  input  logic [SYM_W-1:0] rd_addr,
  output entry_t           rd_data
);

  entry_t mem [NUM_SYMBOLS];
  entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

### hw/rtl/hbp_merge.sv
// hbp_merge: merge stage, appends a table code to the partial byte
// depends on hbp_pkg; fed by the read port of hbp_table

module hbp_merge import hbp_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  logic   take,
  input  logic   take_end,
  input  entry_t entry,
  input  logic   q_full,
  output logic   ready,
  output logic   push,
  output grp_t   grp
);

  logic              s1_valid_r, s1_valid_nxt;
  logic              s1_end_r;
  logic [BYTE_W-1:0] partial_r, partial_nxt;
  logic [2:0]        held_r, held_nxt;

  logic                             fire;
  logic [WORD_W-1:0]                code_m;
  logic [ACC_W-1:0]                 acc;
  logic [LEN_W-1:0]                 total;
  logic [BIDX_W-1:0]                nfull;
  logic [2:0]                       rem;
  logic [GRP_BYTES-1:0][BYTE_W-1:0] wb;
  logic [GCNT_W-1:0]                cnt;

  assign fire  = s1_valid_r && !q_full;
  assign ready = !s1_valid_r || !q_full;

  always_comb begin
    // keep only the top len bits of the code word
    code_m = entry.word & ~(WORD_MASK >> entry.len);
    acc    = {partial_r, {(ACC_W-BYTE_W){1'b0}}}
           | ({code_m, {(ACC_W-WORD_W){1'b0}}} >> held_r);
    total  = LEN_W'(held_r) + entry.len;
    nfull  = total[LEN_W-1:3];
    rem    = total[2:0];
    for (int i = 0; i < GRP_BYTES; i++) begin
      wb[i] = acc[ACC_W-1-BYTE_W*i -: BYTE_W];
    end
    cnt = GCNT_W'(nfull) + GCNT_W'(s1_end_r && (rem != 3'd0));
  end

  assign push       = fire && (cnt != '0);
  assign grp.bytes  = wb;
  assign grp.nbytes = cnt;
  assign grp.is_end = s1_end_r;

  always_comb begin
    s1_valid_nxt = take || (s1_valid_r && !fire);
    partial_nxt  = partial_r;
    held_nxt     = held_r;
    if (fire) begin
      if (s1_end_r) begin
        partial_nxt = '0;
        held_nxt    = '0;
      end else begin
        partial_nxt = wb[nfull];
        held_nxt    = rem;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      partial_r  <= '0;
      held_r     <= '0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      partial_r  <= partial_nxt;
      held_r     <= held_nxt;
    end
    if (take) begin
      s1_end_r <= take_end;
    end
  end

endmodule

### hw/rtl/hbp_queue.sv
// hbp_queue: queue of byte groups, drained one byte per cycle to the output while out_ready is high
// depends on hbp_pkg

module hbp_queue import hbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  grp_t grp,
  output logic full,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  grp_t              q [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;
  logic [BIDX_W-1:0] idx_r, idx_nxt;

  grp_t head;
  logic last;
  logic take;
  logic pop;

  assign head      = q[rd_ptr_r];
  assign full      = (cnt_r == (QPTR_W+1)'(QDEPTH));
  assign out_valid = (cnt_r != '0);
  assign last      = ((GCNT_W'(idx_r) + GCNT_W'(1)) == head.nbytes);
  assign take      = out_valid && out_ready;
  assign pop       = take && last;

  assign out_data.out_byte   = head.bytes[idx_r];
  assign out_data.run_last   = last;
  assign out_data.stream_end = last && head.is_end;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
    idx_nxt    = idx_r;
    if (take) begin
      idx_nxt = last ? '0 : idx_r + BIDX_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
      idx_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
      idx_r    <= idx_nxt;
    end
    if (push) begin
      q[wr_ptr_r] <= grp;
    end
  end

endmodule

### hw/rtl/huffman_bit_packer.sv
// huffman_bit_packer: top level of the canonical huffman bit packer
// depends on hbp_pkg, hbp_table, hbp_merge, hbp_queue
//
//  channel | ports                         | payload | moves
//  --------+-------------------------------+---------+-------------------------------
//  input   | in_valid, in_ready, in_data   | in_t    | load, encode or end request
//  output  | out_valid, out_ready, out_data| out_t   | up to four packed bytes per request
//
// flow: one request can be accepted every cycle while in_ready is high; an encode or
//   end request reads its table entry at acceptance and is merged into the partial
//   byte by the merge stage, which waits while the group queue is full
// the output drains one byte per cycle while out_ready is high, through a
//   four-group queue; a request yields up to four bytes, so sustained input rate
//   is set by out_ready and by the bytes per request
// reset: synchronous, active low; clears the partial byte and the queue.
//   the code table is not cleared and has no clearing pass
// stalls: in_ready drops only while the merge stage holds a request and the
//   group queue is full

module huffman_bit_packer import hbp_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  logic             accept;
  logic             is_load;
  logic             is_enc;
  logic             is_end;
  logic             wr_en;
  entry_t           wr_entry;
  logic             rd_en;
  logic [SYM_W-1:0] rd_addr;
  entry_t           rd_entry;
  logic             q_full;
  logic             push;
  grp_t             grp;

  assign accept  = in_valid && in_ready;
  assign is_load = (in_data.opcode == OP_LOAD);
  assign is_enc  = (in_data.opcode == OP_ENCODE);
  assign is_end  = (in_data.opcode == OP_END);

  // table load; out-of-range symbols are dropped, long lengths saturate
  assign wr_en = accept && is_load && (in_data.symbol < SYM_W'(NUM_SYMBOLS));
  assign wr_entry.len  = (in_data.code_len > LEN_W'(MAX_CODE_LEN)) ?
                         LEN_W'(MAX_CODE_LEN) : in_data.code_len;
  assign wr_entry.word = in_data.code_word;

  // lookup; a load is always accepted before any read that depends on it,
  // so the write-then-read order of the array needs no forwarding
  assign rd_en   = accept && (is_enc || is_end);
  assign rd_addr = is_end ? END_SYMBOL : {1'b0, in_data.data_byte};

  hbp_table u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (in_data.symbol),
    .wr_data (wr_entry),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_entry)
  );

  // merge stage: holds the partial byte and packs the looked-up code
  hbp_merge u_merge (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (rd_en),
    .take_end (is_end),
    .entry    (rd_entry),
    .q_full   (q_full),
    .ready    (in_ready),
    .push     (push),
    .grp      (grp)
  );

  // byte groups wait here and leave one byte per cycle while out_ready is high
  hbp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .grp       (grp),
    .full      (q_full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### hw/rtl/hbp_checker.sv
// hbp_checker: port-level assertions for huffman_bit_packer, bound to the top
// depends on hbp_pkg and huffman_bit_packer

module hbp_checker import hbp_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input out_t out_data
);

  // reset empties the queue
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // reset leaves the merge stage empty, so requests are taken at once
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  // the end-of-stream byte is always the last byte of its request
  a_end_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.stream_end |-> out_data.run_last)
    else $error("stream end without run last");

  // a stalled output byte holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output request changed while stalled");

endmodule

bind huffman_bit_packer hbp_checker u_hbp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

### sim/tb.sv
// tb: self-checking bench for huffman_bit_packer, table of directed requests then random ones
// depends on hbp_pkg, huffman_bit_packer; expected bytes from an in-bench predictor or typed rows
`timescale 1ns / 1ps

module tb;
  import hbp_pkg::*;

  // opcode 3 has no meaning, the block must drop it
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RAND_REQS = 90;
  localparam int MAX_SHOWN = 10;
  localparam int DRAIN_CYCLES = 16;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  in_t  in_data;
  logic out_valid;
  logic out_ready;
  out_t out_data;

  huffman_bit_packer DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs on either channel
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // ---------------------------------------------------------------
  // predictor state: our own copy of the code table and bit buffer
  // ---------------------------------------------------------------
  logic [WORD_W-1:0] code_tbl [NUM_SYMBOLS];
  logic [LEN_W-1:0]  len_tbl  [NUM_SYMBOLS];
  bit                loaded   [NUM_SYMBOLS];
  logic [7:0]        part_byte;   // bits already placed, msb first
  logic [3:0]        free_cnt;    // free bit positions left in part_byte

  // bytes produced by the request being predicted
  out_t grp [GRP_BYTES];
  int   grp_n;

  // bytes still owed by the block, oldest first
  out_t exp_bytes [$];
  int   err_cnt;

  function automatic void put_byte(logic [7:0] b);
    grp[grp_n] = '{out_byte: b, run_last: 1'b0, stream_end: 1'b0};
    grp_n++;
  endfunction

  // append the top bits of one symbol's code, emitting every byte that fills
  function automatic void shift_in_code(logic [SYM_W-1:0] s);
    logic [LEN_W-1:0] n;
    logic [63:0]      acc;
    int               held;
    n    = len_tbl[s];
    held = 8 - free_cnt;
    acc  = 64'(part_byte >> free_cnt);
    acc  = (acc << n) | 64'(code_tbl[s] >> (WORD_W - n));
    held += n;
    while (held >= 8) begin
      put_byte(8'(acc >> (held - 8)));
      held -= 8;
    end
    acc &= (64'd1 << held) - 64'd1;
    part_byte = 8'(acc << (8 - held));
    free_cnt  = 4'(8 - held);
  endfunction

  // works out the bytes one accepted request causes and updates the state
  function automatic void predict_bytes(in_t r);
    grp_n = 0;
    case (r.opcode)
      OP_LOAD: begin
        // out-of-range index is dropped, overlong length saturates
        if (r.symbol < NUM_SYMBOLS) begin
          code_tbl[r.symbol] = r.code_word;
          len_tbl[r.symbol]  = (r.code_len > MAX_CODE_LEN) ? LEN_W'(MAX_CODE_LEN) : r.code_len;
          loaded[r.symbol]   = 1'b1;
        end
      end
      OP_ENCODE: shift_in_code({1'b0, r.data_byte});
      OP_END: begin
        shift_in_code(END_SYMBOL);
        // flush with zero padding; an empty stream end yields nothing
        if (free_cnt < 8) put_byte(part_byte);
        if (grp_n > 0) grp[grp_n-1].stream_end = 1'b1;
        part_byte = '0;
        free_cnt  = 4'd8;
      end
      default: ;
    endcase
    if (grp_n > 0) grp[grp_n-1].run_last = 1'b1;
  endfunction

  function automatic in_t mk_req(logic [1:0] op, int sym, int len, int word, int dbyte);
    in_t r;
    r.opcode    = op;
    r.symbol    = SYM_W'(sym);
    r.code_len  = LEN_W'(len);
    r.code_word = WORD_W'(word);
    r.data_byte = BYTE_W'(dbyte);
    return r;
  endfunction

  // ---------------------------------------------------------------
  // directed table: typed rows carry their bytes, first byte in [31:24]
  // ---------------------------------------------------------------
  typedef struct {
    in_t         req;
    bit          typed;
    int          n;
    logic [31:0] b;
  } step_t;

  step_t steps [$];

  function automatic void add_step(in_t r, bit typed, int n, logic [31:0] b);
    step_t s;
    s.req   = r;
    s.typed = typed;
    s.n     = n;
    s.b     = b;
    steps.push_back(s);
  endfunction

  // ---------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------
  bit in_calm;   // stretch with no gaps between requests
  int sent;

  task automatic send_req(in_t r);
    int gap;
    if (sent % 16 == 0) in_calm = ($urandom_range(0, 2) == 0);
    gap = in_calm ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  task automatic queue_grp();
    for (int i = 0; i < grp_n; i++) exp_bytes.push_back(grp[i]);
  endtask

  initial begin
    in_t   r;
    int    k;
    int    counted;
    int    sym;
    logic [7:0] dbyte;

    rst_n     <= 1'b0;
    in_valid  <= 1'b0;
    in_data   <= '0;
    part_byte = '0;
    free_cnt  = 4'd8;
    err_cnt   = 0;
    sent      = 0;
    for (int i = 0; i < NUM_SYMBOLS; i++) loaded[i] = 1'b0;

    // table entries loaded first so that nothing reads an unwritten one
    add_step(mk_req(OP_LOAD, 0, 8, 'hA50000, 0), 1, 0, '0);
    add_step(mk_req(OP_LOAD, 255, 24, 'hFFFFFF, 0), 1, 0, '0);
    // overlong length saturates to the full word
    add_step(mk_req(OP_LOAD, 1, 31, 'h123456, 0), 1, 0, '0);
    // zero-length code
    add_step(mk_req(OP_LOAD, 2, 0, 'hFFFFFF, 0), 1, 0, '0);
    // bits below the code must not leak out
    add_step(mk_req(OP_LOAD, 3, 3, 'hBFFFFF, 0), 1, 0, '0);
    add_step(mk_req(OP_LOAD, 4, 7, 'hFE0000, 0), 1, 0, '0);
    // end symbol with no bits for the empty stream end
    add_step(mk_req(OP_LOAD, END_SYMBOL, 0, 0, 0), 1, 0, '0);
    // loads past the table are dropped
    add_step(mk_req(OP_LOAD, 257, 5, 'hFFFFFF, 0), 1, 0, '0);
    add_step(mk_req(OP_LOAD, 511, 31, 'hFFFFFF, 0), 1, 0, '0);
    add_step(mk_req(OP_UNUSED, 511, 31, 'hFFFFFF, 255), 1, 0, '0);
    // empty stream end: no bytes, no end mark
    add_step(mk_req(OP_END, 0, 0, 0, 0), 1, 0, '0);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 0), 1, 1, 32'hA5000000);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 255), 1, 3, 32'hFFFFFF00);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 1), 1, 3, 32'h12345600);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 2), 1, 0, '0);
    add_step(mk_req(OP_LOAD, END_SYMBOL, 1, 'h800000, 0), 1, 0, '0);
    add_step(mk_req(OP_END, 0, 0, 0, 0), 1, 1, 32'h80000000);
    // codes straddling byte boundaries
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 3), 0, 0, '0);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 3), 0, 0, '0);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 0), 0, 0, '0);
    add_step(mk_req(OP_END, 0, 0, 0, 0), 0, 0, '0);
    // seven held bits plus a full-width end code: four bytes in one burst
    add_step(mk_req(OP_LOAD, END_SYMBOL, 24, 'hC3C3C3, 0), 1, 0, '0);
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 4), 0, 0, '0);
    add_step(mk_req(OP_END, 0, 0, 0, 0), 0, 0, '0);
    // a fresh stream starts byte-aligned after the end
    add_step(mk_req(OP_ENCODE, 0, 0, 0, 0), 1, 1, 32'hA5000000);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    foreach (steps[i]) begin
      send_req(steps[i].req);
      predict_bytes(steps[i].req);
      if (steps[i].typed) begin
        grp_n = steps[i].n;
        for (int j = 0; j < grp_n; j++) begin
          grp[j].out_byte   = steps[i].b[31-8*j -: 8];
          grp[j].run_last   = (j == grp_n - 1);
          grp[j].stream_end = (j == grp_n - 1) && (steps[i].req.opcode == OP_END);
        end
      end
      queue_grp();
    end

    // random part: mostly encodes of loaded bytes, with reloads, ends and noise
    counted = 0;
    while (counted < RAND_REQS) begin
      k = $urandom_range(0, 99);
      r = mk_req(OP_ENCODE, $urandom_range(0, 511), $urandom_range(0, 31), $urandom,
                 $urandom_range(0, 255));
      if (k < 18) begin
        if (k < 4) sym = END_SYMBOL;
        else if (k == 17) sym = $urandom_range(257, 511);
        else sym = $urandom_range(0, 255);
        r.opcode = OP_LOAD;
        r.symbol = SYM_W'(sym);
        if (sym < NUM_SYMBOLS) counted++;
      end else if (k < 85) begin
        // only bytes whose entry has been written
        do dbyte = 8'($urandom_range(0, 255)); while (!loaded[dbyte]);
        r.data_byte = dbyte;
        counted++;
      end else if (k < 95) begin
        r.opcode = OP_END;
        counted++;
      end else begin
        r.opcode = OP_UNUSED;
      end
      send_req(r);
      predict_bytes(r);
      queue_grp();
    end
    in_valid <= 1'b0;

    // let the queue drain, then watch for stray bytes
    while (exp_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (err_cnt == 0 && exp_bytes.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // ---------------------------------------------------------------
  // output side: random stalls per byte, compare on each handshake
  // ---------------------------------------------------------------
  initial begin
    int   stall;
    int   seen;
    bit   out_calm;
    out_t want;
    out_ready <= 1'b0;
    seen = 0;
    out_calm = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (seen % 16 == 0) out_calm = ($urandom_range(0, 2) == 0);
      stall = out_calm ? 0 : $urandom_range(0, 5);
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      seen++;
      if (exp_bytes.size() == 0) begin
        err_cnt++;
        if (err_cnt <= MAX_SHOWN)
          $display("unexpected byte %02h last %0b end %0b", out_data.out_byte,
                   out_data.run_last, out_data.stream_end);
      end else begin
        want = exp_bytes.pop_front();
        if (out_data.out_byte !== want.out_byte || out_data.run_last !== want.run_last ||
            out_data.stream_end !== want.stream_end) begin
          err_cnt++;
          if (err_cnt <= MAX_SHOWN)
            $display("mismatch: byte exp %02h got %02h, last exp %0b got %0b, end exp %0b got %0b",
                     want.out_byte, out_data.out_byte, want.run_last, out_data.run_last,
                     want.stream_end, out_data.stream_end);
        end
      end
    end
  end

endmodule
